[rtl/core/tvapf_pkg.sv]
// ----------------------------------------------------------------------------
// tvapf_pkg
// shared constants for the time varying all-pole filter core
// ----------------------------------------------------------------------------
package tvapf_pkg;

    // parameter defaults
    localparam int MAX_ORDER_DEF      = 32;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 20;

    // coefficients are Q4.frac
    localparam int COEF_INT_BITS = 4;

    // accumulator width, wraps in two's complement
    localparam int ACC_BITS = 56;

    // item function codes
    localparam logic FUNC_PRIME = 1'b0;
    localparam logic FUNC_COEF  = 1'b1;

    // configuration port
    localparam int          CFG_ADDR_W   = 3;
    localparam int          CFG_DATA_W   = 32;
    localparam int          ORDER_W      = 6;
    localparam int          REG_IDX_W    = 1;
    localparam logic [REG_IDX_W-1:0] REG_IDX_ORDER = 1'b0;
    localparam logic [ORDER_W-1:0]   ORDER_RESET   = 6'd16;

    // effective order is compared on this many bits (holds up to 127)
    localparam int ORD_CMP_W = 7;

endpackage

[rtl/core/time_varying_allpole_filter_core.sv]
// ----------------------------------------------------------------------------
// time_varying_allpole_filter_core
// all-pole recursive filter with per-sample coefficients, fixed point
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries func, sample and coef. a priming
//   transaction (func = 0) pushes sample into the output history and drops any
//   partial sum. a coefficient transaction (func = 1) performs one multiply-
//   accumulate: the first one of an output seeds the accumulator with sample,
//   each one subtracts coef times the history entry it addresses. after
//   filter_order coefficient transactions the rounded, saturated output goes
//   out on the output channel (out_valid/out_ready: y, saturated) and is
//   pushed into the history. filter_order is written through the apb port at
//   byte address 0; the user must do so only while the core is idle, which the
//   core does not enforce. 0 acts as 1, values above MAX_ORDER as MAX_ORDER.
// timing
//   one transaction per cycle sustained unless the stall below holds. a
//   transaction is held in the input register and its result is loaded into
//   the output register when it leaves there, so out_valid rises only after
//   the final coefficient has passed through the input register.
//   the history read, multiplier and accumulator add are combinational logic.
// reset
//   history, accumulator and coefficient counter clear, filter_order is 16.
// stall
//   while the output register holds an untaken result, a coefficient
//   transaction that does not finish an output still proceeds; one that
//   would finish waits in the input register and in_ready drops.
// ----------------------------------------------------------------------------
module time_varying_allpole_filter_core
#(
    parameter int MAX_ORDER      = tvapf_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_BITS    = tvapf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = tvapf_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,

    // apb configuration port
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [tvapf_pkg::CFG_ADDR_W-1:0]           paddr,
    input  logic [tvapf_pkg::CFG_DATA_W-1:0]           pwdata,
    output logic [tvapf_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                       pready,

    // input channel
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic                                       func,
    input  logic signed [SAMPLE_BITS-1:0]              sample,
    input  logic signed [COEF_FRAC_BITS+tvapf_pkg::COEF_INT_BITS-1:0] coef,

    // output channel
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic signed [SAMPLE_BITS-1:0]              y,
    output logic                                       saturated
);

    import tvapf_pkg::*;

    localparam int COEF_BITS = COEF_FRAC_BITS + COEF_INT_BITS;
    localparam int PROD_W    = COEF_BITS + SAMPLE_BITS;
    localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CNT_W     = $clog2(MAX_ORDER + 1);

    // clip limits on the extended rounding width
    localparam logic signed [ACC_BITS:0] SMAX =
        {{(ACC_BITS + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS:0] SMIN = ~SMAX;
    localparam logic signed [ACC_BITS:0] HALF =
        (ACC_BITS + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [ORD_CMP_W-1:0] MAX_ORD_C = ORD_CMP_W'(MAX_ORDER);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [ORDER_W-1:0]   order_reg;
    logic [ORDER_W-1:0]   order_next;
    logic                 cfg_wr;
    logic                 cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W] == REG_IDX_ORDER);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;

    always_comb
    begin
        order_next = order_reg;
        if (cfg_wr)
        begin
            order_next = pwdata[ORDER_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata = CFG_DATA_W'(order_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
        end
        else
        begin
            order_reg <= order_next;
        end
    end

    // effective order, clamped to 1..MAX_ORDER
    logic [ORD_CMP_W-1:0] ord_eff;

    always_comb
    begin
        if (order_reg == '0)
        begin
            ord_eff = ORD_CMP_W'(1);
        end
        else if (ORD_CMP_W'(order_reg) > MAX_ORD_C)
        begin
            ord_eff = MAX_ORD_C;
        end
        else
        begin
            ord_eff = ORD_CMP_W'(order_reg);
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic                          func_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [COEF_BITS-1:0]   coef_reg;
    logic                          fire;
    logic                          emit;

    // stage moves unless it finishes an output into a full result slot
    assign fire     = in_valid_reg && (!emit || !out_valid || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg   <= func;
            sample_reg <= sample;
            coef_reg   <= coef;
        end
    end

    // ------------------------------------------------------------------
    // filter state
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] hist_reg [MAX_ORDER];
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [ACC_BITS-1:0]    acc_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [CNT_W-1:0]              cnt_inc;

    // multiply-accumulate against the addressed history entry
    logic signed [SAMPLE_BITS-1:0] hist_rd;
    logic signed [PROD_W-1:0]      prod;
    logic signed [ACC_BITS-1:0]    acc_base;
    logic signed [ACC_BITS-1:0]    acc_mac;

    assign hist_rd  = hist_reg[cnt_reg[IDX_W-1:0]];
    assign prod     = coef_reg * hist_rd;
    assign acc_base = (cnt_reg == '0) ? (ACC_BITS'(sample_reg) <<< COEF_FRAC_BITS)
                                      : acc_reg;
    assign acc_mac  = acc_base - ACC_BITS'(prod);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign emit     = (func_reg == FUNC_COEF) && (ORD_CMP_W'(cnt_inc) >= ord_eff);

    // round half up, then clip to the sample range
    logic signed [ACC_BITS:0]      rnd;
    logic signed [ACC_BITS:0]      q_full;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic                          sat_next;

    assign rnd    = {acc_mac[ACC_BITS-1], acc_mac} + HALF;
    assign q_full = rnd >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (q_full > SMAX)
        begin
            y_next   = SMAX[SAMPLE_BITS-1:0];
            sat_next = 1'b1;
        end
        else if (q_full < SMIN)
        begin
            y_next   = SMIN[SAMPLE_BITS-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            y_next   = q_full[SAMPLE_BITS-1:0];
            sat_next = 1'b0;
        end
    end

    // state update
    logic                          push;
    logic signed [SAMPLE_BITS-1:0] push_val;

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        push     = 1'b0;
        push_val = y_next;
        if (fire)
        begin
            if (func_reg == FUNC_PRIME)
            begin
                // priming drops any partial sum
                acc_next = '0;
                cnt_next = '0;
                push     = 1'b1;
                push_val = sample_reg;
            end
            else if (emit)
            begin
                acc_next = '0;
                cnt_next = '0;
                push     = 1'b1;
            end
            else
            begin
                acc_next = acc_mac;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    // history shift line, index 0 is newest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ORDER; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            hist_reg[0] <= push_val;
            for (int i = 1; i < MAX_ORDER; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic                          sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            y_reg   <= y_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign y         = y_reg;
    assign saturated = sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // counter never addresses past the history
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ORD_CMP_W'(cnt_reg) < MAX_ORD_C)
        else $error("coefficient counter out of range");

    // a finished output restarts the count and becomes the newest history entry
    a_emit_push: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> out_valid_reg && (cnt_reg == '0) && (hist_reg[0] == y_reg))
        else $error("emitted output not pushed into history");

    // the input side stalls only behind a full result slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && emit)
        else $error("input stalled without a pending result");

    // a priming transaction clears the running sum
    a_prime_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (func_reg == FUNC_PRIME) |=> (cnt_reg == '0) && (acc_reg == '0))
        else $error("priming did not clear the accumulator");

endmodule

[bench/tvapf_output_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tvapf_output_check
// predicts the filter outputs from the observed transactions and compares
// ----------------------------------------------------------------------------
// watches the apb port, the input channel and the output channel. keeps its own
// copy of filter_order, the output history, the partial sum and the coefficient
// count, works out every output the core owes and checks each output
// transaction against the oldest one still owed.
// ----------------------------------------------------------------------------
module tvapf_output_check
#(
    parameter int MAX_ORDER      = tvapf_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_BITS    = tvapf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = tvapf_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,

    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic                                       pready,
    input  logic [tvapf_pkg::CFG_ADDR_W-1:0]           paddr,
    input  logic [tvapf_pkg::CFG_DATA_W-1:0]           pwdata,

    input  logic                                       in_valid,
    input  logic                                       in_ready,
    input  logic                                       func,
    input  logic signed [SAMPLE_BITS-1:0]              sample,
    input  logic signed [COEF_FRAC_BITS+tvapf_pkg::COEF_INT_BITS-1:0] coef,

    input  logic                                       out_valid,
    input  logic                                       out_ready,
    input  logic signed [SAMPLE_BITS-1:0]              y,
    input  logic                                       saturated,

    output int                                         fail_count,
    output int                                         outstanding
);

    import tvapf_pkg::*;

    localparam int COEF_W = COEF_FRAC_BITS + COEF_INT_BITS;
    localparam logic [CFG_ADDR_W-1:0] ORDER_ADDR = CFG_ADDR_W'(4 * REG_IDX_ORDER);
    localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] y;
        logic                          sat;
    } filter_out_t;

    filter_out_t pending_outputs[$];

    logic signed [SAMPLE_BITS-1:0] hist [MAX_ORDER];
    longint                        acc;
    logic [ORDER_W-1:0]            n_coefs;
    logic [ORDER_W-1:0]            order_reg;

    function automatic int eff_order(input logic [ORDER_W-1:0] ord);
        if (ord == 0)
            return 1;
        if (ord > MAX_ORDER)
            return MAX_ORDER;
        return ord;
    endfunction

    task automatic push_hist(input logic signed [SAMPLE_BITS-1:0] v);
        for (int i = MAX_ORDER - 1; i > 0; i--)
            hist[i] = hist[i-1];
        hist[0] = v;
    endtask

    task automatic advance_filter(input logic f, input logic signed [SAMPLE_BITS-1:0] s,
                                  input logic signed [COEF_W-1:0] c);
        longint              sum;
        longint              q;
        logic [ACC_BITS-1:0] wrapped;
        filter_out_t         res;
        if (f == FUNC_PRIME) begin
            push_hist(s);
            acc     = 0;
            n_coefs = '0;
        end
        else begin
            sum     = (n_coefs == 0) ? (longint'(s) <<< COEF_FRAC_BITS) : acc;
            sum     = sum - longint'(c) * longint'(hist[n_coefs % MAX_ORDER]);
            wrapped = sum[ACC_BITS-1:0];
            acc     = longint'($signed(wrapped));
            n_coefs = n_coefs + 1'b1;
            if (n_coefs >= eff_order(order_reg)) begin
                // round half up, then clip to the sample range
                q       = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
                res.sat = 1'b0;
                if (q > SAMPLE_HI) begin
                    q       = SAMPLE_HI;
                    res.sat = 1'b1;
                end
                else if (q < SAMPLE_LO) begin
                    q       = SAMPLE_LO;
                    res.sat = 1'b1;
                end
                res.y = q[SAMPLE_BITS-1:0];
                push_hist(res.y);
                acc     = 0;
                n_coefs = '0;
                pending_outputs.push_back(res);
            end
        end
    endtask

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%t: %s", $realtime, msg);
    endtask

    task automatic check_output();
        filter_out_t want;
        if (pending_outputs.size() == 0)
            note_fail($sformatf("output with nothing owed: y=%0d saturated=%0b",
                                y, saturated));
        else begin
            want = pending_outputs.pop_front();
            if (y !== want.y || saturated !== want.sat)
                note_fail($sformatf("expected y=%0d saturated=%0b, got y=%0d saturated=%0b",
                                    $signed(want.y), want.sat, y, saturated));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ORDER; i++)
                hist[i] = '0;
            acc        = 0;
            n_coefs    = '0;
            order_reg  = ORDER_RESET;
            fail_count = 0;
            pending_outputs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ORDER_ADDR)
                order_reg = pwdata[ORDER_W-1:0];
            if (in_valid && in_ready)
                advance_filter(func, sample, coef);
            if (out_valid && out_ready)
                check_output();
            outstanding <= pending_outputs.size();
        end
    end

endmodule

[bench/tb_time_varying_allpole_filter_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_varying_allpole_filter_core
// self-checking bench for the time varying all-pole filter core
// ----------------------------------------------------------------------------
// a short directed sequence hits the sample and coefficient extremes, clipping
// to the low limit, rounding of half a step, an output abandoned by a priming
// transaction, an order lowered while a sum is open and the out of range order
// setting 0. random phases follow, one per filter_order setting, built mostly
// from well-formed rows (priming, then whole outputs) with random content plus
// abandoned outputs and loose transactions. both channels idle at random.
// tvapf_output_check predicts and compares, this module drives and judges.
// ----------------------------------------------------------------------------
module tb_time_varying_allpole_filter_core;

    import tvapf_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int COEF_W      = COEF_FRAC_BITS_DEF + COEF_INT_BITS;
    localparam int MAX_ORDER   = MAX_ORDER_DEF;

    localparam int ITEM_TARGET  = 1700;  // random transactions, roughly
    localparam int PHASE_ITEMS  = 170;   // transactions per order setting
    localparam int MAX_GAP      = 14;    // longest idle stretch on either side
    localparam int SETTLE_WAIT  = 6;     // margin after the last owed output
    localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction

    localparam logic [CFG_ADDR_W-1:0] ORDER_ADDR = CFG_ADDR_W'(4 * REG_IDX_ORDER);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]      COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]      COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    // 0.5 in q4.20
    localparam logic signed [COEF_W-1:0]      COEF_HALF  = COEF_W'(1) << (COEF_FRAC_BITS_DEF - 1);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // apb side, idle until a register write
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // input channel
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          func     = FUNC_PRIME;
    logic signed [SAMPLE_BITS-1:0] sample   = '0;
    logic signed [COEF_W-1:0]      coef     = '0;

    // output channel
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          saturated;

    int fail_count;
    int outstanding;

    int n_items     = 0;
    int n_settings  = 0;
    int n_results   = 0;
    int n_clipped   = 0;
    int idle_cycles = 0;

    bit in_quiet  = 1'b0;   // sender runs back to back
    bit out_quiet = 1'b0;   // receiver never stalls
    int ready_hold = 0;

    // order settings for the first random phases: extremes and out of range first
    int order_plan [10] = '{1, 32, 63, 0, 2, 5, 16, 31, 33, 8};

    always #4 clk = ~clk;

    time_varying_allpole_filter_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .sample    (sample),
        .coef      (coef),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .y         (y),
        .saturated (saturated)
    );

    tvapf_output_check u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .sample      (sample),
        .coef        (coef),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .y           (y),
        .saturated   (saturated),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // ------------------------------------------------------------------------
    // receiver: after each output transaction draw a random stall, possibly none,
    // and now and then switch to a stretch with no stalls at all
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if ($urandom_range(0, 63) == 0)
                out_quiet = !out_quiet;
            ready_hold = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
        end
        else if (ready_hold != 0)
            ready_hold = ready_hold - 1;
        out_ready <= (ready_hold == 0);
    end

    // run statistics for the summary
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            n_results <= n_results + 1;
            if (saturated)
                n_clipped <= n_clipped + 1;
        end
    end

    // watchdog: any transaction on any port counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d outputs still owed",
                     IDLE_LIMIT, outstanding);
            $display("tb_time_varying_allpole_filter_core NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one input transaction; returns at the edge that took it, valid still high
    // so that a back to back transaction needs no second assignment to valid
    task automatic send_item(input logic f, input logic signed [SAMPLE_BITS-1:0] s,
                             input logic signed [COEF_W-1:0] c);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        sample   <= s;
        coef     <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_items++;
    endtask

    // stop sending, wait until every owed output has gone out and the
    // pipeline has emptied behind the last transaction
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_order(input int ord);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ORDER_ADDR;
        pwdata  <= CFG_DATA_W'(ord);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    function automatic int active_order(input int ord);
        if (ord == 0)
            return 1;
        if (ord > MAX_ORDER)
            return MAX_ORDER;
        return ord;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_BITS'(int'($urandom_range(0, 2047)) - 1024);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // three in eight of the coefficients keep the sum of |a| at or below one so that the
    // recursion stays bounded and most outputs are not clipped
    function automatic logic signed [COEF_W-1:0] rand_coef(input int ord);
        int lim;
        lim = (1 << COEF_FRAC_BITS_DEF) / ord;
        case ($urandom_range(0, 7))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return '0;
            3, 4:    return COEF_W'($urandom());
            default: return COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
        endcase
    endfunction

    task automatic send_output(input int ord);
        for (int i = 0; i < ord; i++)
            send_item(FUNC_COEF, rand_sample(), rand_coef(ord));
    endtask

    // one order setting worth of traffic
    task automatic run_phase(input int ord, input int budget);
        int stop_at;
        int pick;
        int n_prime;
        stop_at = n_items + budget;
        while (n_items < stop_at)
        begin
            in_quiet = ($urandom_range(0, 4) == 0);
            pick     = $urandom_range(0, 99);
            if (pick < 75)
            begin
                // regular row: load the history, then whole outputs
                n_prime = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ord + 2) : ord;
                repeat (n_prime)
                    send_item(FUNC_PRIME, rand_sample(), rand_coef(ord));
                repeat ($urandom_range(1, 6))
                    send_output(ord);
            end
            else if (pick < 90)
            begin
                // output cut short by a priming transaction
                if (ord > 1)
                    repeat ($urandom_range(1, ord - 1))
                        send_item(FUNC_COEF, rand_sample(), rand_coef(ord));
                send_item(FUNC_PRIME, rand_sample(), rand_coef(ord));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    send_item(1'($urandom_range(0, 1)), rand_sample(), rand_coef(ord));
            end
        end
        // sometimes leave a sum open so the next setting picks it up
        if (ord > 1 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, ord - 1))
                send_item(FUNC_COEF, rand_sample(), rand_coef(ord));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        int ord;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // order still at its reset value of 16, history all zero: five
        // coefficients leave an open sum seeded with the largest sample
        send_item(FUNC_COEF, SAMPLE_MAX, COEF_MAX);
        send_item(FUNC_COEF, SAMPLE_MIN, COEF_MIN);
        send_item(FUNC_COEF, '0, COEF_MAX);
        send_item(FUNC_COEF, '0, '0);
        send_item(FUNC_COEF, '0, COEF_MIN);
        wait_idle();

        // lowering the order below the count finishes the open output with the next coefficient
        write_order(1);
        send_item(FUNC_COEF, SAMPLE_MIN, COEF_HALF);

        // clip low: smallest sample minus a large product of the largest
        send_item(FUNC_COEF, SAMPLE_MIN, COEF_MAX);
        // clip low again: smallest coefficient times the smallest history entry
        send_item(FUNC_PRIME, SAMPLE_MIN, '0);
        send_item(FUNC_COEF, SAMPLE_MAX, COEF_MIN);
        send_item(FUNC_PRIME, SAMPLE_MAX, COEF_MAX);
        send_item(FUNC_PRIME, '0, COEF_MIN);

        // exactly half a step either way rounds up
        send_item(FUNC_PRIME, SAMPLE_BITS'(1), '0);
        send_item(FUNC_COEF, '0, COEF_HALF);
        send_item(FUNC_PRIME, SAMPLE_BITS'(1), '0);
        send_item(FUNC_COEF, '0, -COEF_HALF);
        wait_idle();

        // priming in the middle of an output drops the partial sum
        write_order(4);
        send_item(FUNC_COEF, SAMPLE_MAX, COEF_MAX);
        send_item(FUNC_COEF, SAMPLE_MIN, COEF_MIN);
        send_item(FUNC_PRIME, SAMPLE_BITS'(12345), COEF_MAX);
        send_item(FUNC_COEF, SAMPLE_BITS'(-777), COEF_HALF);
        send_item(FUNC_COEF, SAMPLE_MAX, -COEF_HALF);
        send_item(FUNC_COEF, SAMPLE_MIN, COEF_MAX);
        send_item(FUNC_COEF, '0, COEF_MIN);
        wait_idle();

        // order 0 behaves as order 1
        write_order(0);
        send_item(FUNC_COEF, SAMPLE_BITS'(1000), COEF_HALF);

        // --- random phases, one order setting each ---
        phase = 0;
        while (n_items < ITEM_TARGET + 23)
        begin
            ord = (phase < 10) ? order_plan[phase] : $urandom_range(0, 63);
            wait_idle();
            write_order(ord);
            run_phase(active_order(ord), PHASE_ITEMS);
            phase++;
        end
        wait_idle();

        $display("ran %0d input transactions across %0d filter_order settings (0 and 63 included)",
                 n_items, n_settings);
        $display("compared %0d outputs, %0d of them clipped to the sample range",
                 n_results, n_clipped);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_time_varying_allpole_filter_core OK");
        else
            $display("tb_time_varying_allpole_filter_core NOT OK");
        $finish;
    end

endmodule
